FILE: hw/rtl/tpqm_pkg.sv
// Shared constants and register indexes for the touch point qualify and map unit.
`timescale 1ns / 1ps
`default_nettype none
package tpqm_pkg;

  localparam int ADC_BITS  = 12;
  localparam int PROD_W    = 2 * ADC_BITS;
  localparam int SCR_W     = 16;
  localparam int CNT_W     = $clog2(ADC_BITS);
  localparam int CFG_IDX_W = 3;

  localparam logic [SCR_W-1:0]    NO_POINT = 16'hFFFF;
  localparam logic [ADC_BITS-1:0] ADC_MAX  = {ADC_BITS{1'b1}};

  localparam logic OP_QUALIFY = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  localparam logic [ADC_BITS-1:0] RST_CAL_LOW  = ADC_BITS'(200);
  localparam logic [ADC_BITS-1:0] RST_CAL_HIGH = ADC_BITS'(3800);
  localparam logic [ADC_BITS-1:0] RST_SCR_X    = ADC_BITS'(239);
  localparam logic [ADC_BITS-1:0] RST_SCR_Y    = ADC_BITS'(319);
  localparam logic [ADC_BITS-1:0] RST_JITTER   = ADC_BITS'(200);

  localparam logic [CFG_IDX_W-1:0] REG_CAL_X_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_X_HIGH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_Y_LOW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_Y_HIGH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_X_TOP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_Y_TOP = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_JITTER_LIMIT = 3'd6;

endpackage
`default_nettype wire

FILE: hw/rtl/touch_point_qualify_and_map_unit.sv
// Top level: qualifies touch samples, tracks extremes and maps points to screen space.
//
// One request is taken at a time. A clear request or a rejected sample goes from
// capture to qualify and then to the result register; a qualified point is captured,
// then qualified and averaged, then for each axis takes a step on the shared 12x12
// multiplier and then on the shared restoring divider, which retires one quotient
// bit a cycle, and at last is loaded into the result register once that is free. An
// axis whose calibration window is empty skips the divider and maps to 0. The result
// register lets the next request be accepted while the previous result is waiting.
`timescale 1ns / 1ps
`default_nettype none
module touch_point_qualify_and_map_unit import tpqm_pkg::*; (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     cfg_we,
  input  wire [CFG_IDX_W-1:0]     cfg_index,
  input  wire [ADC_BITS-1:0]      cfg_wdata,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire                     in_op,
  input  wire                     in_down_before_first,
  input  wire [ADC_BITS-1:0]      in_first_x,
  input  wire [ADC_BITS-1:0]      in_first_y,
  input  wire                     in_down_before_second,
  input  wire [ADC_BITS-1:0]      in_second_x,
  input  wire [ADC_BITS-1:0]      in_second_y,
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic                    out_touched,
  output logic [SCR_W-1:0]        out_screen_x,
  output logic [SCR_W-1:0]        out_screen_y,
  output logic [ADC_BITS-1:0]     out_raw_x_last,
  output logic [ADC_BITS-1:0]     out_raw_y_last,
  output logic [ADC_BITS-1:0]     out_seen_x_min,
  output logic [ADC_BITS-1:0]     out_seen_x_max,
  output logic [ADC_BITS-1:0]     out_seen_y_min,
  output logic [ADC_BITS-1:0]     out_seen_y_max
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_QUAL = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_r;

  logic [ADC_BITS-1:0] cal_x_low_r, cal_x_high_r, cal_y_low_r, cal_y_high_r;
  logic [ADC_BITS-1:0] screen_x_top_r, screen_y_top_r, jitter_limit_r;

  logic [ADC_BITS-1:0] last_x_r, last_y_r;
  logic [ADC_BITS-1:0] min_x_r, max_x_r, min_y_r, max_y_r;

  logic                op_r, d1_r, d2_r;
  logic [ADC_BITS-1:0] x1_r, y1_r, x2_r, y2_r;
  logic [ADC_BITS-1:0] ax_r, ay_r;
  logic                touched_r;
  logic [SCR_W-1:0]    qx_r, qy_r;
  logic                axis_r;
  logic [PROD_W-1:0]   acc_r;
  logic [ADC_BITS-1:0] den_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                out_valid_r;
  logic                res_load;

  // qualify
  logic [ADC_BITS-1:0] dx, dy;
  logic [ADC_BITS:0]   sum_x, sum_y;
  logic [ADC_BITS-1:0] avg_x, avg_y;
  logic                qual_ok;

  always_comb begin
    dx      = (x1_r > x2_r) ? (x1_r - x2_r) : (x2_r - x1_r);
    dy      = (y1_r > y2_r) ? (y1_r - y2_r) : (y2_r - y1_r);
    sum_x   = {1'b0, x1_r} + {1'b0, x2_r};
    sum_y   = {1'b0, y1_r} + {1'b0, y2_r};
    avg_x   = sum_x[ADC_BITS:1];
    avg_y   = sum_y[ADC_BITS:1];
    qual_ok = d1_r && d2_r && (dx <= jitter_limit_r) && (dy <= jitter_limit_r);
  end

  // shared multiplier stage operands
  logic [ADC_BITS-1:0] m_v, m_lo, m_hi, m_top, m_clamp;
  logic                win_ok;

  always_comb begin
    m_v     = axis_r ? ay_r : ax_r;
    m_lo    = axis_r ? cal_y_low_r : cal_x_low_r;
    m_hi    = axis_r ? cal_y_high_r : cal_x_high_r;
    m_top   = axis_r ? screen_y_top_r : screen_x_top_r;
    win_ok  = m_hi > m_lo;
    m_clamp = (m_v < m_lo) ? m_lo : ((m_v > m_hi) ? m_hi : m_v);
  end

  // shared restoring divider step
  logic [ADC_BITS:0]   div_try;
  logic                div_bit;
  logic [ADC_BITS-1:0] div_rem;
  logic [PROD_W-1:0]   acc_nxt;

  always_comb begin
    div_try = {acc_r[PROD_W-1:ADC_BITS], acc_r[ADC_BITS-1]};
    div_bit = div_try >= {1'b0, den_r};
    div_rem = div_bit ? ADC_BITS'(div_try - {1'b0, den_r}) : div_try[ADC_BITS-1:0];
    acc_nxt = {div_rem, acc_r[ADC_BITS-2:0], div_bit};
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign res_load  = (state_r == S_FIN) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_x_low_r    <= RST_CAL_LOW;
      cal_x_high_r   <= RST_CAL_HIGH;
      cal_y_low_r    <= RST_CAL_LOW;
      cal_y_high_r   <= RST_CAL_HIGH;
      screen_x_top_r <= RST_SCR_X;
      screen_y_top_r <= RST_SCR_Y;
      jitter_limit_r <= RST_JITTER;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAL_X_LOW:    cal_x_low_r    <= cfg_wdata;
        REG_CAL_X_HIGH:   cal_x_high_r   <= cfg_wdata;
        REG_CAL_Y_LOW:    cal_y_low_r    <= cfg_wdata;
        REG_CAL_Y_HIGH:   cal_y_high_r   <= cfg_wdata;
        REG_SCREEN_X_TOP: screen_x_top_r <= cfg_wdata;
        REG_SCREEN_Y_TOP: screen_y_top_r <= cfg_wdata;
        REG_JITTER_LIMIT: jitter_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      axis_r      <= 1'b0;
      cnt_r       <= '0;
      last_x_r    <= '0;
      last_y_r    <= '0;
      min_x_r     <= ADC_MAX;
      max_x_r     <= '0;
      min_y_r     <= ADC_MAX;
      max_y_r     <= '0;
    end else begin
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= in_op;
            d1_r    <= in_down_before_first;
            d2_r    <= in_down_before_second;
            x1_r    <= in_first_x;
            y1_r    <= in_first_y;
            x2_r    <= in_second_x;
            y2_r    <= in_second_y;
            state_r <= S_QUAL;
          end
        end
        S_QUAL: begin
          axis_r <= 1'b0;
          qx_r   <= NO_POINT;
          qy_r   <= NO_POINT;
          if (op_r == OP_CLEAR) begin
            min_x_r   <= ADC_MAX;
            max_x_r   <= '0;
            min_y_r   <= ADC_MAX;
            max_y_r   <= '0;
            touched_r <= 1'b0;
            state_r   <= S_FIN;
          end else if (qual_ok) begin
            ax_r      <= avg_x;
            ay_r      <= avg_y;
            last_x_r  <= avg_x;
            last_y_r  <= avg_y;
            if (avg_x < min_x_r) min_x_r <= avg_x;
            if (avg_x > max_x_r) max_x_r <= avg_x;
            if (avg_y < min_y_r) min_y_r <= avg_y;
            if (avg_y > max_y_r) max_y_r <= avg_y;
            touched_r <= 1'b1;
            state_r   <= S_MUL;
          end else begin
            touched_r <= 1'b0;
            state_r   <= S_FIN;
          end
        end
        S_MUL: begin
          acc_r <= PROD_W'(m_clamp - m_lo) * PROD_W'(m_top);
          den_r <= m_hi - m_lo;
          cnt_r <= '0;
          if (win_ok) begin
            state_r <= S_DIV;
          end else if (!axis_r) begin
            qx_r   <= '0;
            axis_r <= 1'b1;
          end else begin
            qy_r    <= '0;
            state_r <= S_FIN;
          end
        end
        S_DIV: begin
          acc_r <= acc_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(ADC_BITS - 1)) begin
            if (!axis_r) begin
              qx_r    <= {{(SCR_W-ADC_BITS){1'b0}}, acc_nxt[ADC_BITS-1:0]};
              axis_r  <= 1'b1;
              state_r <= S_MUL;
            end else begin
              qy_r    <= {{(SCR_W-ADC_BITS){1'b0}}, acc_nxt[ADC_BITS-1:0]};
              state_r <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (res_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (res_load) begin
      out_touched    <= touched_r;
      out_screen_x   <= qx_r;
      out_screen_y   <= qy_r;
      out_raw_x_last <= last_x_r;
      out_raw_y_last <= last_y_r;
      out_seen_x_min <= min_x_r;
      out_seen_x_max <= max_x_r;
      out_seen_y_min <= min_y_r;
      out_seen_y_max <= max_y_r;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/tpqm_checker.sv
// Port-level checker for the touch point qualify and map unit, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module tpqm_checker import tpqm_pkg::*; (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_valid,
  input wire                 in_ready,
  input wire                 out_valid,
  input wire                 out_ready,
  input wire                 out_touched,
  input wire [SCR_W-1:0]     out_screen_x,
  input wire [SCR_W-1:0]     out_screen_y,
  input wire [ADC_BITS-1:0]  out_raw_x_last,
  input wire [ADC_BITS-1:0]  out_raw_y_last,
  input wire [ADC_BITS-1:0]  out_seen_x_min,
  input wire [ADC_BITS-1:0]  out_seen_x_max,
  input wire [ADC_BITS-1:0]  out_seen_y_min,
  input wire [ADC_BITS-1:0]  out_seen_y_max
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_screen_x) && $stable(out_screen_y))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous one in flight");

  a_no_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_touched |-> out_screen_x == NO_POINT && out_screen_y == NO_POINT)
    else $error("untouched result carries coordinates");

  a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_touched |-> out_screen_x[SCR_W-1:ADC_BITS] == '0 &&
      out_screen_y[SCR_W-1:ADC_BITS] == '0)
    else $error("mapped coordinate out of range");

  a_extremes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_touched |-> out_seen_x_min <= out_raw_x_last &&
      out_raw_x_last <= out_seen_x_max && out_seen_y_min <= out_raw_y_last &&
      out_raw_y_last <= out_seen_y_max)
    else $error("extremes do not cover last point");

endmodule

bind touch_point_qualify_and_map_unit tpqm_checker u_tpqm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_touched    (out_touched),
  .out_screen_x   (out_screen_x),
  .out_screen_y   (out_screen_y),
  .out_raw_x_last (out_raw_x_last),
  .out_raw_y_last (out_raw_y_last),
  .out_seen_x_min (out_seen_x_min),
  .out_seen_x_max (out_seen_x_max),
  .out_seen_y_min (out_seen_y_min),
  .out_seen_y_max (out_seen_y_max)
);
`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the touch point qualify and map unit.
`timescale 1ns / 1ps
module testbench;
  import tpqm_pkg::*;

  localparam logic PEN_DOWN   = 1'b1;
  localparam logic PEN_UP     = 1'b0;

  localparam int STALL_LIMIT   = 4000;
  localparam int LONG_HOLD     = 200;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 40;

  typedef struct packed {
    logic                op;
    logic                down_first;
    logic [ADC_BITS-1:0] first_x;
    logic [ADC_BITS-1:0] first_y;
    logic                down_second;
    logic [ADC_BITS-1:0] second_x;
    logic [ADC_BITS-1:0] second_y;
  } touch_req_t;

  typedef struct packed {
    logic                touched;
    logic [SCR_W-1:0]    screen_x;
    logic [SCR_W-1:0]    screen_y;
    logic [ADC_BITS-1:0] raw_x_last;
    logic [ADC_BITS-1:0] raw_y_last;
    logic [ADC_BITS-1:0] seen_x_min;
    logic [ADC_BITS-1:0] seen_x_max;
    logic [ADC_BITS-1:0] seen_y_min;
    logic [ADC_BITS-1:0] seen_y_max;
  } touch_res_t;

  typedef logic [REG_JITTER_LIMIT:0][ADC_BITS-1:0] cal_set_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ADC_BITS-1:0]  cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_op = 1'b0;
  logic                 in_down_before_first = 1'b0;
  logic [ADC_BITS-1:0]  in_first_x = '0;
  logic [ADC_BITS-1:0]  in_first_y = '0;
  logic                 in_down_before_second = 1'b0;
  logic [ADC_BITS-1:0]  in_second_x = '0;
  logic [ADC_BITS-1:0]  in_second_y = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_touched;
  logic [SCR_W-1:0]     out_screen_x;
  logic [SCR_W-1:0]     out_screen_y;
  logic [ADC_BITS-1:0]  out_raw_x_last;
  logic [ADC_BITS-1:0]  out_raw_y_last;
  logic [ADC_BITS-1:0]  out_seen_x_min;
  logic [ADC_BITS-1:0]  out_seen_x_max;
  logic [ADC_BITS-1:0]  out_seen_y_min;
  logic [ADC_BITS-1:0]  out_seen_y_max;

  touch_res_t          pending_points[$];
  cal_set_t            cal_now;
  logic [ADC_BITS-1:0] avg_x, avg_y, lo_x_seen, hi_x_seen, lo_y_seen, hi_y_seen;
  int unsigned         send_gap_pct = 0;
  int unsigned         recv_gap_pct = 0;
  int unsigned         fault_count = 0;
  logic                receiver_hold = 1'b0;
  event                receiver_hold_evt;

  touch_point_qualify_and_map_unit dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_op                 (in_op),
    .in_down_before_first  (in_down_before_first),
    .in_first_x            (in_first_x),
    .in_first_y            (in_first_y),
    .in_down_before_second (in_down_before_second),
    .in_second_x           (in_second_x),
    .in_second_y           (in_second_y),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_touched           (out_touched),
    .out_screen_x          (out_screen_x),
    .out_screen_y          (out_screen_y),
    .out_raw_x_last        (out_raw_x_last),
    .out_raw_y_last        (out_raw_y_last),
    .out_seen_x_min        (out_seen_x_min),
    .out_seen_x_max        (out_seen_x_max),
    .out_seen_y_min        (out_seen_y_min),
    .out_seen_y_max        (out_seen_y_max)
  );

  always #1 clk = ~clk;

  function automatic cal_set_t calibration(logic [ADC_BITS-1:0] x_lo, logic [ADC_BITS-1:0] x_hi,
                                           logic [ADC_BITS-1:0] y_lo, logic [ADC_BITS-1:0] y_hi,
                                           logic [ADC_BITS-1:0] x_top,
                                           logic [ADC_BITS-1:0] y_top,
                                           logic [ADC_BITS-1:0] jitter);
    cal_set_t c;
    c[REG_CAL_X_LOW]    = x_lo;
    c[REG_CAL_X_HIGH]   = x_hi;
    c[REG_CAL_Y_LOW]    = y_lo;
    c[REG_CAL_Y_HIGH]   = y_hi;
    c[REG_SCREEN_X_TOP] = x_top;
    c[REG_SCREEN_Y_TOP] = y_top;
    c[REG_JITTER_LIMIT] = jitter;
    return c;
  endfunction

  function automatic void clear_seen_span();
    lo_x_seen = ADC_MAX;
    hi_x_seen = '0;
    lo_y_seen = ADC_MAX;
    hi_y_seen = '0;
  endfunction

  function automatic void reset_touch_model();
    cal_now = calibration(RST_CAL_LOW, RST_CAL_HIGH, RST_CAL_LOW, RST_CAL_HIGH,
                          RST_SCR_X, RST_SCR_Y, RST_JITTER);
    avg_x = '0;
    avg_y = '0;
    clear_seen_span();
  endfunction

  function automatic logic [ADC_BITS-1:0] reading_spread(logic [ADC_BITS-1:0] a,
                                                         logic [ADC_BITS-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [SCR_W-1:0] scale_to_screen(logic [ADC_BITS-1:0] v,
                                                       logic [ADC_BITS-1:0] lo,
                                                       logic [ADC_BITS-1:0] hi,
                                                       logic [ADC_BITS-1:0] top);
    logic [ADC_BITS-1:0] held;
    logic [PROD_W-1:0]   prod;
    if (hi <= lo) return '0;
    held = (v < lo) ? lo : ((v > hi) ? hi : v);
    prod = PROD_W'(held - lo) * PROD_W'(top);
    return SCR_W'(prod / PROD_W'(hi - lo));
  endfunction

  function automatic touch_res_t qualify_and_map(touch_req_t r);
    touch_res_t        res;
    logic [ADC_BITS:0] sum_x, sum_y;
    res.touched  = 1'b0;
    res.screen_x = NO_POINT;
    res.screen_y = NO_POINT;
    if (r.op == OP_CLEAR) begin
      clear_seen_span();
    end else if (r.down_first && r.down_second &&
                 reading_spread(r.first_x, r.second_x) <= cal_now[REG_JITTER_LIMIT] &&
                 reading_spread(r.first_y, r.second_y) <= cal_now[REG_JITTER_LIMIT]) begin
      sum_x = {1'b0, r.first_x} + {1'b0, r.second_x};
      sum_y = {1'b0, r.first_y} + {1'b0, r.second_y};
      avg_x = sum_x[ADC_BITS:1];
      avg_y = sum_y[ADC_BITS:1];
      if (avg_x < lo_x_seen) lo_x_seen = avg_x;
      if (avg_x > hi_x_seen) hi_x_seen = avg_x;
      if (avg_y < lo_y_seen) lo_y_seen = avg_y;
      if (avg_y > hi_y_seen) hi_y_seen = avg_y;
      res.touched  = 1'b1;
      res.screen_x = scale_to_screen(avg_x, cal_now[REG_CAL_X_LOW], cal_now[REG_CAL_X_HIGH],
                                     cal_now[REG_SCREEN_X_TOP]);
      res.screen_y = scale_to_screen(avg_y, cal_now[REG_CAL_Y_LOW], cal_now[REG_CAL_Y_HIGH],
                                     cal_now[REG_SCREEN_Y_TOP]);
    end
    res.raw_x_last = avg_x;
    res.raw_y_last = avg_y;
    res.seen_x_min = lo_x_seen;
    res.seen_x_max = hi_x_seen;
    res.seen_y_min = lo_y_seen;
    res.seen_y_max = hi_y_seen;
    return res;
  endfunction

  function automatic touch_req_t point_req(logic op, logic d1, logic [ADC_BITS-1:0] x1,
                                           logic [ADC_BITS-1:0] y1, logic d2,
                                           logic [ADC_BITS-1:0] x2,
                                           logic [ADC_BITS-1:0] y2);
    touch_req_t r;
    r.op          = op;
    r.down_first  = d1;
    r.first_x     = x1;
    r.first_y     = y1;
    r.down_second = d2;
    r.second_x    = x2;
    r.second_y    = y2;
    return r;
  endfunction

  function automatic logic [ADC_BITS-1:0] nudge(logic [ADC_BITS-1:0] base, int delta);
    int v;
    v = $urandom_range(1) ? int'(base) + delta : int'(base) - delta;
    if (v > int'(ADC_MAX)) v = int'(base) - delta;
    if (v < 0) v = int'(base) + delta;
    if (v > int'(ADC_MAX)) v = int'(ADC_MAX);
    return ADC_BITS'(v);
  endfunction

  function automatic touch_req_t random_request();
    touch_req_t  r;
    int          jit;
    int unsigned kind;
    jit  = int'(cal_now[REG_JITTER_LIMIT]);
    kind = $urandom_range(99);
    r = point_req(OP_QUALIFY, PEN_DOWN, ADC_BITS'($urandom_range(4095)),
                  ADC_BITS'($urandom_range(4095)), PEN_DOWN,
                  ADC_BITS'($urandom_range(4095)), ADC_BITS'($urandom_range(4095)));
    if (kind < 6) begin
      r.op          = OP_CLEAR;
      r.down_first  = 1'($urandom_range(1));
      r.down_second = 1'($urandom_range(1));
    end else if (kind < 80) begin
      r.second_x = nudge(r.first_x, ($urandom_range(7) == 0) ? jit : $urandom_range(jit));
      r.second_y = nudge(r.first_y, ($urandom_range(7) == 0) ? jit : $urandom_range(jit));
    end else if (kind < 90) begin
      r.second_x = nudge(r.first_x, $urandom_range(jit));
      r.second_y = nudge(r.first_y, $urandom_range(jit));
      if (jit == int'(ADC_MAX) || $urandom_range(3) == 0) begin
        if ($urandom_range(1)) r.down_first = PEN_UP;
        else r.down_second = PEN_UP;
      end else if ($urandom_range(1)) begin
        r.second_x = nudge(r.first_x, jit + 1);
      end else begin
        r.second_y = nudge(r.first_y, jit + 1);
      end
    end else begin
      r.down_first  = 1'($urandom_range(1));
      r.down_second = 1'($urandom_range(1));
    end
    return r;
  endfunction

  function automatic cal_set_t random_calibration();
    cal_set_t             c;
    int unsigned          lo, hi;
    logic [CFG_IDX_W-1:0] lo_reg, hi_reg;
    for (int axis = 0; axis < 2; axis++) begin
      lo_reg = axis ? REG_CAL_Y_LOW : REG_CAL_X_LOW;
      hi_reg = axis ? REG_CAL_Y_HIGH : REG_CAL_X_HIGH;
      case ($urandom_range(9))
        0: begin
          lo = $urandom_range(4095);
          hi = lo;
        end
        1: begin
          lo = $urandom_range(4095, 1);
          hi = $urandom_range(lo - 1, 0);
        end
        default: begin
          lo = $urandom_range(2047);
          hi = $urandom_range(4095, lo + 1);
        end
      endcase
      c[lo_reg] = ADC_BITS'(lo);
      c[hi_reg] = ADC_BITS'(hi);
    end
    c[REG_SCREEN_X_TOP] = ADC_BITS'($urandom_range(1) ? $urandom_range(4095)
                                                      : $urandom_range(480));
    c[REG_SCREEN_Y_TOP] = ADC_BITS'($urandom_range(1) ? $urandom_range(4095)
                                                      : $urandom_range(480));
    case ($urandom_range(3))
      0: c[REG_JITTER_LIMIT] = ADC_BITS'($urandom_range(20));
      1: c[REG_JITTER_LIMIT] = ADC_BITS'($urandom_range(400));
      2: c[REG_JITTER_LIMIT] = ADC_BITS'($urandom_range(4095));
      default: c[REG_JITTER_LIMIT] = ADC_MAX;
    endcase
    return c;
  endfunction

  function automatic string result_text(touch_res_t r);
    return $sformatf("touched=%0d x=%0d y=%0d raw=%0d,%0d x_span=%0d..%0d y_span=%0d..%0d",
                     r.touched, r.screen_x, r.screen_y, r.raw_x_last, r.raw_y_last,
                     r.seen_x_min, r.seen_x_max, r.seen_y_min, r.seen_y_max);
  endfunction

  task automatic note_fault(string what);
    fault_count++;
    if (fault_count <= 10) $display("%s", what);
  endtask

  task automatic check_point();
    touch_res_t got, want;
    got = {out_touched, out_screen_x, out_screen_y, out_raw_x_last, out_raw_y_last,
           out_seen_x_min, out_seen_x_max, out_seen_y_min, out_seen_y_max};
    if (pending_points.size() == 0) begin
      note_fault({"unexpected result: ", result_text(got)});
    end else begin
      want = pending_points.pop_front();
      if (got !== want)
        note_fault({"mismatch: expected ", result_text(want), " got ", result_text(got)});
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_point();
    out_ready <= !receiver_hold && ($urandom_range(99) >= recv_gap_pct);
  end

  always begin
    @(receiver_hold_evt);
    receiver_hold <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    receiver_hold <= 1'b0;
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("testbench: errors");
    $finish;
  end

  task automatic program_calibration(cal_set_t c);
    for (int i = 0; i <= int'(REG_JITTER_LIMIT); i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= c[i];
      @(posedge clk);
    end
    cfg_we  <= 1'b0;
    cal_now = c;
  endtask

  task automatic send_request(touch_req_t r);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_op, in_down_before_first, in_first_x, in_first_y,
     in_down_before_second, in_second_x, in_second_y} <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_points.push_back(qualify_and_map(r));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed_points();
    send_gap_pct = 0;
    recv_gap_pct = 0;
    program_calibration(calibration(RST_CAL_LOW, RST_CAL_HIGH, RST_CAL_LOW, RST_CAL_HIGH,
                                    RST_SCR_X, RST_SCR_Y, RST_JITTER));
    send_request(point_req(OP_QUALIFY, PEN_DOWN, 12'd2000, 12'd2000,
                           PEN_DOWN, 12'd2000, 12'd2000));
    send_request(point_req(OP_QUALIFY, PEN_DOWN, 12'd1001, 12'd3001,
                           PEN_DOWN, 12'd1002, 12'd3002));
    send_request(point_req(OP_QUALIFY, PEN_UP, 12'd1500, 12'd1500,
                           PEN_DOWN, 12'd1500, 12'd1500));
    send_request(point_req(OP_QUALIFY, PEN_DOWN, 12'd1500, 12'd1500,
                           PEN_UP, 12'd1500, 12'd1500));
    send_request(point_req(OP_QUALIFY, PEN_DOWN, 12'd500, 12'd900,
                           PEN_DOWN, 12'd700, 12'd900));
    send_request(point_req(OP_QUALIFY, PEN_DOWN, 12'd500, 12'd900,
                           PEN_DOWN, 12'd701, 12'd900));
    send_request(point_req(OP_QUALIFY, PEN_DOWN, 12'd500, 12'd900,
                           PEN_DOWN, 12'd500, 12'd1101));
    send_request(point_req(OP_QUALIFY, PEN_DOWN, 12'd500, 12'd1100,
                           PEN_DOWN, 12'd500, 12'd900));
    send_request(point_req(OP_QUALIFY, PEN_DOWN, 12'd0, 12'd0, PEN_DOWN, 12'd0, 12'd0));
    send_request(point_req(OP_QUALIFY, PEN_DOWN, 12'd4095, 12'd4095,
                           PEN_DOWN, 12'd4095, 12'd4095));
    send_request(point_req(OP_QUALIFY, PEN_DOWN, 12'd200, 12'd200,
                           PEN_DOWN, 12'd200, 12'd200));
    send_request(point_req(OP_QUALIFY, PEN_DOWN, 12'd3800, 12'd3800,
                           PEN_DOWN, 12'd3800, 12'd3800));
    send_request(point_req(OP_CLEAR, PEN_DOWN, 12'd4095, 12'd4095,
                           PEN_DOWN, 12'd4095, 12'd4095));
    send_request(point_req(OP_QUALIFY, PEN_DOWN, 12'd1500, 12'd2500,
                           PEN_DOWN, 12'd1600, 12'd2400));
    wait_for_results();
    program_calibration(calibration('0, '0, '0, '0, '0, '0, '0));
    send_request(point_req(OP_QUALIFY, PEN_DOWN, 12'd4095, 12'd4095,
                           PEN_DOWN, 12'd4095, 12'd4095));
    send_request(point_req(OP_QUALIFY, PEN_DOWN, 12'd4095, 12'd0,
                           PEN_DOWN, 12'd4094, 12'd0));
    send_request(point_req(OP_CLEAR, PEN_UP, 12'd0, 12'd0, PEN_UP, 12'd0, 12'd0));
    wait_for_results();
    program_calibration(calibration(ADC_MAX, ADC_MAX, ADC_MAX, ADC_MAX,
                                    ADC_MAX, ADC_MAX, ADC_MAX));
    send_request(point_req(OP_QUALIFY, PEN_DOWN, 12'd0, 12'd4095,
                           PEN_DOWN, 12'd4095, 12'd0));
    send_request(point_req(OP_QUALIFY, PEN_UP, 12'd4095, 12'd4095,
                           PEN_UP, 12'd4095, 12'd4095));
    wait_for_results();
    program_calibration(calibration('0, ADC_MAX, 12'd3000, 12'd1000,
                                    ADC_MAX, ADC_MAX, ADC_MAX));
    send_request(point_req(OP_QUALIFY, PEN_DOWN, 12'd4095, 12'd4095,
                           PEN_DOWN, 12'd4095, 12'd4095));
    send_request(point_req(OP_QUALIFY, PEN_DOWN, 12'd0, 12'd0, PEN_DOWN, 12'd0, 12'd0));
    send_request(point_req(OP_QUALIFY, PEN_DOWN, 12'd1234, 12'd3000,
                           PEN_DOWN, 12'd1236, 12'd2990));
    wait_for_results();
  endtask

  task automatic test_receiver_backpressure();
    send_gap_pct = 0;
    recv_gap_pct = 0;
    program_calibration(calibration(RST_CAL_LOW, RST_CAL_HIGH, RST_CAL_LOW, RST_CAL_HIGH,
                                    RST_SCR_X, RST_SCR_Y, RST_JITTER));
    -> receiver_hold_evt;
    repeat (16) send_request(random_request());
    wait_for_results();
    repeat (8) send_request(random_request());
    wait_for_results();
  endtask

  task automatic test_random_traffic(int unsigned send_pct, int unsigned recv_pct, int count);
    send_gap_pct = send_pct;
    recv_gap_pct = recv_pct;
    for (int batch = 0; batch < 3; batch++) begin
      program_calibration(random_calibration());
      for (int n = 0; n < count / 3; n++) send_request(random_request());
      wait_for_results();
    end
  endtask

  initial begin
    reset_touch_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_points();
    test_receiver_backpressure();
    test_random_traffic(29, 46, 270);
    test_random_traffic(46, 29, 270);
    test_random_traffic(0, 0, 270);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/tpqm_pkg.sv
hw/rtl/touch_point_qualify_and_map_unit.sv
hw/rtl/tpqm_checker.sv
sim/testbench.sv
